// ----- src/rlmu_pkg.sv -----
// shared types and constants for the ring lattice metropolis update block
`default_nettype none
package rlmu_pkg;
	localparam int unsigned KC_BITS = 24;
	localparam int unsigned SS_BITS = 16;
	localparam int unsigned RND_BITS = 16;
	localparam int unsigned WIND_BITS = 7;
	localparam logic [1:0] REG_KINETIC = 2'd0;
	localparam logic [1:0] REG_STEP = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_RD_PN,
		ST_RD_MN,
		ST_GAPS,
		ST_SQ,
		ST_SUM,
		ST_MUL,
		ST_DECIDE,
		ST_OUT
	} exec_state_t;

	// exp(-k/32) table in 32 fraction bits, one-to-one with the recursion T[k]
	function automatic logic [32:0] exp_entry(input logic [11:0] k);
		logic [32:0] t;
		logic [65:0] p;
		t = 33'h1_0000_0000;
		for (int i = 0; i < 4096; i++) begin
			if (i < int'(k)) begin
				p = 66'(t) * 66'd4162825044 + 66'h8000_0000;
				t = p[64:32];
			end
		end
		return t;
	endfunction
endpackage
`default_nettype wire

// ----- src/rlmu_ram.sv -----
// generic single port ram with registered read
`default_nettype none
module rlmu_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- src/rlmu_front.sv -----
// input side: takes items and queues them for the execution side
`default_nettype none
module rlmu_front import rlmu_pkg::*; #(
	parameter int unsigned W = 38
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              q_valid,
	input  wire logic         q_ready,
	output logic [W-1:0]      q_data
);
	// two entry queue
	logic [W-1:0] ent_q [2];
	logic         rd_q, wr_q;
	logic [1:0]   cnt_q;
	logic         push, pop;
	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = ent_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= in_data;
	end
endmodule
`default_nettype wire

// ----- src/rlmu_back.sv -----
// execution side: reads neighbors, forms energy change, decides, writes back
`default_nettype none
module rlmu_back import rlmu_pkg::*; #(
	parameter int unsigned SITES = 64,
	parameter int unsigned POS_BITS = 16,
	parameter int unsigned EXP_ENTRIES = 256,
	localparam int unsigned AW = (SITES > 1) ? $clog2(SITES) : 1,
	localparam int unsigned LSW = AW + POS_BITS + 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [KC_BITS-1:0]   kinetic_coeff,
	input  wire logic [SS_BITS-1:0]   step_size,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire logic [5:0]           q_site,
	input  wire logic [RND_BITS-1:0]  q_rs,
	input  wire logic [RND_BITS-1:0]  q_ra,
	output logic                      o_valid,
	input  wire logic                 o_ready,
	output logic                      o_accepted,
	output logic [15:0]               o_position,
	output logic [WIND_BITS-1:0]      o_winding
);
	localparam int unsigned PW = POS_BITS;
	localparam int unsigned GW = PW + 1;
	localparam int unsigned SH = 32 - PW;
	localparam int unsigned DPTH = 1 << AW;
	localparam int unsigned EW = (EXP_ENTRIES > 1) ? $clog2(EXP_ENTRIES) : 1;

	exec_state_t st_q, st_d;
	logic [RND_BITS-1:0] ra_q;
	logic [AW-1:0] r_q, rp_q, rm_q;
	logic inrange_q;
	logic [PW-1:0] old_q, pn_q, mn_q, trial_q;
	logic signed [GW-1:0] g_po_q, g_om_q, g_pt_q, g_tm_q;
	logic [31:0] sq_q [4];
	logic signed [34:0] s_q;
	logic signed [60:0] prod_q;
	logic acc_q;
	logic signed [LSW-1:0] ls_q;
	logic [15:0] pos_out_q;
	logic o_valid_q;
	logic o_acc_q;
	logic [15:0] o_pos_q;
	logic [DPTH-1:0] vld_q;

	// memory port
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [PW-1:0] ram_rd, rd_val;
	rlmu_ram #(.WIDTH(PW), .DEPTH(DPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(trial_q), .rdata(ram_rd)
	);
	logic [AW-1:0] rd_addr_q;
	assign rd_val = vld_q[rd_addr_q] ? ram_rd : PW'(1) << (PW - 1);

	function automatic logic signed [GW-1:0] ring_gap(input logic [PW-1:0] a,
		input logic [PW-1:0] b);
		logic signed [GW:0] raw;
		logic signed [GW:0] half;
		raw = $signed({2'b0, a}) - $signed({2'b0, b});
		half = (GW+1)'(1) <<< (PW - 1);
		if (raw > half) raw = raw - ((GW+1)'(1) <<< PW);
		else if (raw < -half) raw = raw + ((GW+1)'(1) <<< PW);
		return raw[GW-1:0];
	endfunction

	function automatic logic [15:0] to_q16(input logic [PW-1:0] a);
		logic [PW+15:0] w;
		w = {a, 16'b0} >> PW;
		return w[15:0];
	endfunction

	function automatic logic [31:0] gsq(input logic signed [GW-1:0] g);
		logic [GW-1:0] m;
		logic [15:0] q;
		logic [PW+15:0] w;
		m = g[GW-1] ? GW'(-g) : GW'(g);
		w = {m[PW-1:0], 16'b0} >> PW;
		// magnitude of one half turn is exactly 2^(PW-1)
		q = w[15:0];
		return 32'(q) * 32'(q);
	endfunction

	// proposal step
	logic signed [17:0] fac;
	logic signed [34:0] mprod;
	logic signed [34:0] mv;
	assign fac = 18'sd65536 - $signed({1'b0, q_rs, 1'b0});
	assign mprod = $signed({1'b0, step_size}) * fac;
	always_comb begin
		if (!mprod[34]) mv = mprod >>> SH;
		else mv = -((-mprod + 35'((64'(1) << SH) - 1)) >>> SH);
	end

	// winding from link sum, half away from zero
	logic [LSW-1:0] mag, rnd;
	logic signed [LSW-1:0] wind;
	assign mag = ls_q[LSW-1] ? LSW'(-ls_q) : LSW'(ls_q);
	assign rnd = (mag + (LSW'(1) << (PW - 1))) >> PW;
	assign wind = ls_q[LSW-1] ? -$signed(rnd) : $signed(rnd);

	// exp(-k/32) values, fixed at elaboration
	logic [32:0] exp_tab [EXP_ENTRIES];
	for (genvar gk = 0; gk < EXP_ENTRIES; gk++) begin : g_exp
		localparam logic [32:0] TV = exp_entry(12'(gk));
		assign exp_tab[gk] = TV;
	end

	// acceptance index and table lookup
	logic [60:0] kraw;
	logic [25:0] kidx;
	logic [EW-1:0] eidx;
	logic [32:0] tval;
	assign kraw = (61'(prod_q) + (61'(1) << 34)) >> 35;
	assign kidx = kraw[25:0];
	assign eidx = kidx[EW-1:0];
	assign tval = exp_tab[eidx];

	logic start;
	assign start = (st_q == ST_IDLE) && q_valid;

	always_comb begin
		st_d = st_q;
		q_ready = 1'b0;
		ram_addr = r_q;
		case (st_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) st_d = (32'(q_site) < SITES) ? ST_RD_OLD : ST_OUT;
				ram_addr = AW'(q_site);
			end
			ST_RD_OLD: begin ram_addr = rp_q; st_d = ST_RD_PN; end
			ST_RD_PN:  begin ram_addr = rm_q; st_d = ST_RD_MN; end
			ST_RD_MN:  st_d = ST_GAPS;
			ST_GAPS:   st_d = ST_SQ;
			ST_SQ:     st_d = ST_SUM;
			ST_SUM:    st_d = ST_MUL;
			ST_MUL:    st_d = ST_DECIDE;
			ST_DECIDE: st_d = ST_OUT;
			ST_OUT: begin
				if (!o_valid_q) st_d = ST_IDLE;
			end
			default:   st_d = ST_IDLE;
		endcase
	end

	logic dec_acc;
	assign dec_acc = prod_q[60] ||
		((kidx < 26'(EXP_ENTRIES)) && ({ra_q, 16'b0} < tval));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ls_q <= '0;
			vld_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (o_valid_q && o_ready) o_valid_q <= 1'b0;
			if (st_q == ST_DECIDE && dec_acc) begin
				vld_q[r_q] <= 1'b1;
				ls_q <= ls_q + ((LSW'(g_pt_q) + LSW'(g_tm_q))
					- (LSW'(g_po_q) + LSW'(g_om_q)));
			end
			if (st_q == ST_OUT && !o_valid_q) o_valid_q <= 1'b1;
		end
	end
	assign ram_we = (st_q == ST_DECIDE) && dec_acc;

	always_ff @(posedge clk) begin
		rd_addr_q <= ram_addr;
		if (start) begin
			r_q <= AW'(q_site);
			rp_q <= (32'(q_site) + 1 == SITES) ? '0 : AW'(q_site) + AW'(1);
			rm_q <= (q_site == '0) ? AW'(SITES - 1) : AW'(q_site) - AW'(1);
			ra_q <= q_ra;
			inrange_q <= (32'(q_site) < SITES);
			trial_q <= PW'(mv);
			acc_q <= 1'b0;
			pos_out_q <= '0;
		end
		case (st_q)
			ST_RD_OLD: begin
				old_q <= rd_val;
				trial_q <= rd_val + trial_q;
			end
			ST_RD_PN:  pn_q <= rd_val;
			ST_RD_MN:  mn_q <= rd_val;
			ST_GAPS: begin
				g_po_q <= ring_gap(pn_q, old_q);
				g_om_q <= ring_gap(old_q, mn_q);
				g_pt_q <= ring_gap(pn_q, trial_q);
				g_tm_q <= ring_gap(trial_q, mn_q);
			end
			ST_SQ: begin
				sq_q[0] <= gsq(g_pt_q);
				sq_q[1] <= gsq(g_tm_q);
				sq_q[2] <= gsq(g_po_q);
				sq_q[3] <= gsq(g_om_q);
			end
			ST_SUM: s_q <= ($signed(35'(sq_q[0])) + $signed(35'(sq_q[1])))
				- ($signed(35'(sq_q[2])) + $signed(35'(sq_q[3])));
			ST_MUL: prod_q <= $signed({1'b0, kinetic_coeff}) * s_q;
			ST_DECIDE: begin
				acc_q <= dec_acc;
				pos_out_q <= to_q16(dec_acc ? trial_q : old_q);
			end
			default: ;
		endcase
		// result register, stable while the receiver stalls
		if (st_q == ST_OUT && !o_valid_q) begin
			o_winding <= WIND_BITS'(wind);
			o_acc_q <= acc_q & inrange_q;
			o_pos_q <= inrange_q ? pos_out_q : 16'd0;
		end
	end

	assign o_valid = o_valid_q;
	assign o_accepted = o_acc_q;
	assign o_position = o_pos_q;
endmodule
`default_nettype wire

// ----- src/ring_lattice_metropolis_update_top.sv -----
// top level of the ring lattice metropolis update block
// channels: s_axis carries one update item (site, rand_step, rand_accept);
// m_axis returns one result item per update (accepted, position, winding);
// the apb port writes kinetic_coeff (address 0) and step_size (address 4)
// a two entry queue decouples input acceptance from the execution sequencer
// an in-range site steps through the states read old, read plus neighbor, read minus neighbor,
// gaps, square, sum, multiply, decide and output; a site beyond the ring goes straight to output
// the sequencer takes a new item only once the last is through, so its rate is set by three
// serial reads of the single position memory, the square, sum and multiply steps and write-back
// reset: positions read as one half turn (per-entry valid bits), link sum zero,
// kinetic_coeff 8192, step_size 32768
// when the receiver stalls the result holds in the output register, the
// sequencer waits and the input queue fills, then s_axis_tready drops
`default_nettype none
module ring_lattice_metropolis_update_top import rlmu_pkg::*; #(
	parameter int unsigned SITES = 64,
	parameter int unsigned POS_BITS = 16,
	parameter int unsigned EXP_ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // site[5:0], rand_step[21:6], rand_accept[37:22]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // accepted[0], position[16:1], winding[23:17]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [KC_BITS-1:0] kc_q;
	logic [SS_BITS-1:0] ss_q;
	logic [1:0] reg_idx;
	assign reg_idx = paddr[2] ? REG_STEP : REG_KINETIC;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q <= KC_BITS'(8192);
			ss_q <= SS_BITS'(32768);
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (reg_idx == REG_KINETIC) kc_q <= pwdata[KC_BITS-1:0];
			else ss_q <= pwdata[SS_BITS-1:0];
		end
	end
	always_comb begin
		case (reg_idx)
			REG_KINETIC: prdata = {8'b0, kc_q};
			REG_STEP:    prdata = {16'b0, ss_q};
			default:     prdata = '0;
		endcase
	end

	// input queue
	logic q_valid, q_ready;
	logic [37:0] q_data;
	rlmu_front #(.W(38)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata[37:0]),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	// execution sequencer
	logic acc;
	logic [15:0] pos;
	logic [WIND_BITS-1:0] wnd;
	rlmu_back #(.SITES(SITES), .POS_BITS(POS_BITS), .EXP_ENTRIES(EXP_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.kinetic_coeff(kc_q), .step_size(ss_q),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_site(q_data[5:0]), .q_rs(q_data[21:6]), .q_ra(q_data[37:22]),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
		.o_accepted(acc), .o_position(pos), .o_winding(wnd)
	);
	assign m_axis_tdata = {wnd, pos, acc};
endmodule
`default_nettype wire

// ----- tb/tb_ring_lattice_metropolis_update_top.sv -----
// testbench for the ring lattice metropolis update block: directed table, random phases, predictor
`default_nettype none
module tb_ring_lattice_metropolis_update_top;
	import rlmu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	// stream and register port signals
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;     // site[5:0], rand_step[21:6], rand_accept[37:22]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;          // accepted[0], position[16:1], winding[23:17]
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ring_lattice_metropolis_update_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
		.m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// one result item as the block reports it
	typedef struct packed {
		logic [6:0]  wind;
		logic [15:0] pos;
		logic        acc;
	} update_result_t;

	// directed row: typed result used only where it is obvious
	typedef struct {
		logic [5:0]     site;
		logic [15:0]    rs;
		logic [15:0]    ra;
		bit             typed;
		update_result_t res;
	} update_row_t;

	// predictor state
	logic [15:0] ring_pos [64];
	longint ring_link_sum;
	logic [23:0] kin_coeff;
	logic [15:0] step_max;
	longint unsigned boltz_tab [256];

	update_result_t results_due [$];
	int errors = 0;
	bit quiet = 1'b0;      // no idling near the end
	bit hold_req = 1'b0;   // ask the receiver for one long stall

	function automatic longint ring_dist(input longint a, input longint b);
		longint raw;
		raw = a - b;
		if (raw >= -32768 && raw <= 32768) return raw;
		if (raw > 32768) return raw - 65536;
		return raw + 65536;
	endfunction

	function automatic logic [6:0] winding_now();
		longint w;
		if (ring_link_sum >= 0) w = (ring_link_sum + 32768) >>> 16;
		else w = -((-ring_link_sum + 32768) >>> 16);
		return w[6:0];
	endfunction

	// metropolis step on the predictor state
	function automatic update_result_t metropolis_step(input logic [5:0] st,
			input logic [15:0] rs, input logic [15:0] ra);
		update_result_t res;
		int r, rp, rm;
		longint m, mv, old, trial, pn, mn, gpo, gom, gpt, gtm, s, prod;
		longint unsigned k;
		bit acc;
		r = st;
		rp = (r == 63) ? 0 : r + 1;
		rm = (r == 0) ? 63 : r - 1;
		old = ring_pos[r];
		pn = ring_pos[rp];
		mn = ring_pos[rm];
		m = longint'(step_max) * (65536 - 2 * longint'(rs));
		mv = m >>> 16;
		trial = (old + mv) & 64'hFFFF;
		gpo = ring_dist(pn, old);
		gom = ring_dist(old, mn);
		gpt = ring_dist(pn, trial);
		gtm = ring_dist(trial, mn);
		s = (gpt * gpt + gtm * gtm) - (gpo * gpo + gom * gom);
		prod = longint'(kin_coeff) * s;
		acc = 1'b0;
		if (prod < 0) acc = 1'b1;
		else begin
			k = (longint'(prod) + (64'd1 << 34)) >> 35;
			if (k < 256 && (longint'(ra) << 16) < boltz_tab[k]) acc = 1'b1;
		end
		if (acc) begin
			ring_pos[r] = trial[15:0];
			ring_link_sum += (gpt + gtm) - (gpo + gom);
		end
		res.acc = acc;
		res.pos = ring_pos[r];
		res.wind = winding_now();
		return res;
	endfunction

	// sender: optional gap, then hold the item until accepted
	task automatic send_update(input logic [5:0] st, input logic [15:0] rs,
			input logic [15:0] ra, input bit typed, input update_result_t tres);
		update_result_t res;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, ra, rs, st};
		do @(posedge clk); while (!s_tready);
		res = metropolis_step(st, rs, ra);
		results_due.push_back(typed ? tres : res);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == {REG_KINETIC, 1'b0} << 1) kin_coeff = val[23:0];
		else step_max = val[15:0];
	endtask

	// let the block drain before touching registers
	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver: random stalls, one long hold, checks on every accepted item
	int stall_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		update_result_t want, got;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result item %h", $realtime, got);
			end else begin
				want = results_due.pop_front();
				if (got.acc !== want.acc) begin
					errors++;
					$display("%0t: accepted exp %0d got %0d", $realtime, want.acc, got.acc);
				end
				if (got.pos !== want.pos) begin
					errors++;
					$display("%0t: position exp %h got %h", $realtime, want.pos, got.pos);
				end
				if (got.wind !== want.wind) begin
					errors++;
					$display("%0t: winding exp %h got %h", $realtime, want.wind, got.wind);
				end
			end
		end
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			stall_left <= 400;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// random item: some small steps and some small accept values so moves get accepted, the rest full range
	task automatic send_random();
		logic [15:0] rs, ra;
		rs = $urandom_range(0, 65535);
		ra = $urandom_range(0, 65535);
		case ($urandom_range(0, 3))
			0: rs = 16'd32768 + 16'($urandom_range(0, 2047)) - 16'd1024;
			1: ra = 16'($urandom_range(0, 255));
			default: ;
		endcase
		send_update(6'($urandom_range(0, 63)), rs, ra, 1'b0, '0);
	endtask

	update_row_t rows [14];
	initial begin
		for (int i = 0; i < 64; i++) ring_pos[i] = 16'h8000;
		ring_link_sum = 0;
		kin_coeff = 24'd8192;
		step_max = 16'd32768;
		boltz_tab[0] = 64'd1 << 32;
		for (int i = 1; i < 256; i++)
			boltz_tab[i] = (boltz_tab[i - 1] * 64'd4162825044 + (64'd1 << 31)) >> 32;

		// zero step after reset reads back one half, equal energy accepts
		rows[0] = '{6'd0, 16'h8000, 16'hFFFF, 1'b1, '{7'd0, 16'h8000, 1'b1}};
		rows[1] = '{6'd0, 16'h0000, 16'hFFFF, 1'b0, '0};   // step of exactly one half
		rows[2] = '{6'd1, 16'hFFFF, 16'h0000, 1'b0, '0};
		rows[3] = '{6'd63, 16'h0000, 16'h0000, 1'b0, '0};  // wraps to site zero
		rows[4] = '{6'd63, 16'hFFFF, 16'hFFFF, 1'b0, '0};
		rows[5] = '{6'd31, 16'h4000, 16'h0001, 1'b0, '0};
		rows[6] = '{6'd32, 16'hC000, 16'h8000, 1'b0, '0};
		rows[7] = '{6'd0, 16'h7FFF, 16'h0000, 1'b0, '0};
		rows[8] = '{6'd62, 16'h8001, 16'hFFFF, 1'b0, '0};
		rows[9] = '{6'd21, 16'h5555, 16'hAAAA, 1'b0, '0};
		rows[10] = '{6'd42, 16'hAAAA, 16'h5555, 1'b0, '0};
		rows[11] = '{6'd1, 16'h8000, 16'h0000, 1'b0, '0};
		rows[12] = '{6'd2, 16'h0000, 16'hFFFF, 1'b0, '0};
		rows[13] = '{6'd3, 16'hFFFF, 16'h7FFF, 1'b0, '0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[i]) send_update(rows[i].site, rows[i].rs, rows[i].ra,
			rows[i].typed, rows[i].res);
		drain();

		// phases over the register extremes and random settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin apb_write(3'd0, 32'd0); apb_write(3'd4, 32'd65535); end
				1: begin apb_write(3'd0, 32'hFFFFFF); apb_write(3'd4, 32'd0); end
				2: begin apb_write(3'd0, 32'd256); apb_write(3'd4, 32'd32768); end
				default: begin
					apb_write(3'd0, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4095));
					apb_write(3'd4, $urandom);
				end
			endcase
			if (ph == 2) hold_req = 1'b1;
			if (ph == 5) quiet = 1'b1;
			repeat (230) send_random();
			drain();
		end

		while (results_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
src/rlmu_pkg.sv
src/rlmu_ram.sv
src/rlmu_front.sv
src/rlmu_back.sv
src/ring_lattice_metropolis_update_top.sv
tb/tb_ring_lattice_metropolis_update_top.sv
